// ===== rtl/rpct_pkg.sv =====
// ----------------------------------------------------------------------------
// rpct_pkg
// Shared widths, register indexes and reset values of the red pixel centroid
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rpct_pkg;

  localparam int PIX_W    = 8;
  localparam int OTHERS_W = 9;
  localparam int FW_W     = 11;
  localparam int CENT_W   = 10;
  localparam int COUNT_W  = 21;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OTHERS_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd2;

  localparam logic [PIX_W-1:0]    RED_MIN_RESET     = 8'd200;
  localparam logic [OTHERS_W-1:0] OTHERS_MAX_RESET  = 9'd100;
  localparam logic [FW_W-1:0]     FRAME_WIDTH_RESET = 11'd320;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== rtl/rpct_front.sv =====
// ----------------------------------------------------------------------------
// rpct_front
// Holds the configuration registers, tests each pixel against the color
// thresholds and tracks its column and row in the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rpct_front #(
  parameter int MAX_WIDTH  = rpct_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rpct_pkg::DEF_MAX_HEIGHT,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [rpct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpct_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic [rpct_pkg::PIX_W-1:0]       pixel_blue,
  input  logic [rpct_pkg::PIX_W-1:0]       pixel_green,
  input  logic [rpct_pkg::PIX_W-1:0]       pixel_red,
  input  logic                             last_in_frame,
  output logic [CW+RW+1:0]                 item
);
  import rpct_pkg::*;

  localparam int EWW = (FW_W > CW + 1) ? FW_W : CW + 1;

  logic [PIX_W-1:0]    red_min;
  logic [OTHERS_W-1:0] others_max;
  logic [FW_W-1:0]     frame_width;
  logic [CW-1:0]       column;
  logic [RW-1:0]       row;

  logic [EWW-1:0]      width_ext;
  logic [EWW-1:0]      eff_width;
  logic [EWW-1:0]      column_inc;
  logic [OTHERS_W-1:0] others_sum;
  logic                red;

  always_comb begin
    width_ext = EWW'(frame_width);
    if (frame_width == '0) begin
      eff_width = EWW'(1);
    end else if (width_ext > EWW'(MAX_WIDTH)) begin
      eff_width = EWW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    column_inc = EWW'(column) + EWW'(1);
    others_sum = OTHERS_W'(pixel_green) + OTHERS_W'(pixel_blue);
    red        = (pixel_red > red_min) && (others_sum < others_max);
  end

  assign item = {red, last_in_frame, column, row};

  always_ff @(posedge clk) begin
    if (rst) begin
      red_min     <= RED_MIN_RESET;
      others_max  <= OTHERS_MAX_RESET;
      frame_width <= FRAME_WIDTH_RESET;
      column      <= '0;
      row         <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_RED_MIN:     red_min     <= PIX_W'(cfg_data);
          REG_OTHERS_MAX:  others_max  <= OTHERS_W'(cfg_data);
          REG_FRAME_WIDTH: frame_width <= FW_W'(cfg_data);
          default: ;
        endcase
      end
      if (accept) begin
        if (last_in_frame) begin
          column <= '0;
          row    <= '0;
        end else if (column_inc >= eff_width) begin
          column <= '0;
          if (32'(row) + 32'd1 < 32'(MAX_HEIGHT)) begin
            row <= row + RW'(1);
          end
        end else begin
          column <= column + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpct_queue.sv =====
// ----------------------------------------------------------------------------
// rpct_queue
// Small first-in first-out queue of classified pixels between the front and
// the back of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module rpct_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rpct_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import rpct_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpct_div.sv =====
// ----------------------------------------------------------------------------
// rpct_div
// Restoring divider that produces one quotient bit per cycle, for quotients
// known to fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rpct_div #(
  parameter int DW = 16,
  parameter int NW = 8,
  parameter int QW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);
  import rpct_pkg::*;

  localparam int SW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] shifted;
  logic [SW-1:0] steps;
  logic          busy;
  logic          fits;

  assign fits = (rem >= shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= SW'(QW);
        rem      <= dividend;
        shifted  <= DW'(divisor) << (QW - 1);
        quotient <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - shifted;
        end
        quotient <= (quotient << 1) | QW'(fits);
        shifted  <= shifted >> 1;
        steps    <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpct_back.sv =====
// ----------------------------------------------------------------------------
// rpct_back
// Accumulates the coordinates of red pixels, forms the rounded centroid at
// the end of each frame and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpct_back #(
  parameter int MAX_WIDTH  = rpct_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rpct_pkg::DEF_MAX_HEIGHT,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  logic [CW+RW+1:0]               q_data,
  output logic                           q_pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           is_red,
  output logic                           frame_done,
  output logic [rpct_pkg::CENT_W-1:0]    centroid_x,
  output logic [rpct_pkg::CENT_W-1:0]    centroid_y,
  output logic [rpct_pkg::COUNT_W-1:0]   red_count
);
  import rpct_pkg::*;

  localparam int TALLY_CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int TW        = $clog2(TALLY_CAP + 1);
  localparam int QW        = (CW > RW) ? CW : RW;
  localparam int SXW       = TW + CW;
  localparam int SYW       = TW + RW;
  localparam int DW        = TW + QW + 1;
  localparam int NW        = TW + 1;

  typedef enum logic [2:0] {
    S_PASS,
    S_START,
    S_DIV_X,
    S_DIV_Y,
    S_EMIT
  } state_t;

  state_t         state;
  logic [SXW-1:0] sum_x;
  logic [SYW-1:0] sum_y;
  logic [TW-1:0]  tally;
  logic [QW-1:0]  quot_x;
  logic           frame_red;

  logic           px_red;
  logic           px_last;
  logic [CW-1:0]  px_col;
  logic [RW-1:0]  px_row;
  logic           out_free;
  logic           take;
  logic           load_result;

  logic           div_start;
  logic           div_done;
  logic [DW-1:0]  div_dividend;
  logic [NW-1:0]  div_divisor;
  logic [QW-1:0]  div_quot;

  assign px_red  = q_data[CW+RW+1];
  assign px_last = q_data[CW+RW];
  assign px_col  = q_data[RW +: CW];
  assign px_row  = q_data[0 +: RW];

  assign out_free    = !result_valid || !result_stall;
  assign q_pop       = (state == S_PASS) && q_valid && out_free;
  assign take        = px_red && (tally < TW'(TALLY_CAP));
  assign load_result = (q_pop && !px_last) || ((state == S_EMIT) && out_free);

  assign div_start   = (state == S_START) || ((state == S_DIV_X) && div_done);
  assign div_divisor = {tally, 1'b0};

  always_comb begin
    if (state == S_DIV_X) begin
      div_dividend = (DW'(sum_y) << 1) + DW'(tally);
    end else begin
      div_dividend = (DW'(sum_x) << 1) + DW'(tally);
    end
  end

  rpct_div #(
    .DW (DW),
    .NW (NW),
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_PASS;
      result_valid <= 1'b0;
      sum_x        <= '0;
      sum_y        <= '0;
      tally        <= '0;
    end else begin
      if (result_valid && !result_stall && !load_result) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_PASS: begin
          if (q_pop) begin
            if (take) begin
              sum_x <= sum_x + SXW'(px_col);
              sum_y <= sum_y + SYW'(px_row);
              tally <= tally + TW'(1);
            end
            if (px_last) begin
              frame_red <= px_red;
              state     <= S_START;
            end else begin
              result_valid <= 1'b1;
              is_red       <= px_red;
              frame_done   <= 1'b0;
              centroid_x   <= '0;
              centroid_y   <= '0;
              red_count    <= '0;
            end
          end
        end
        S_START: begin
          state <= S_DIV_X;
        end
        S_DIV_X: begin
          if (div_done) begin
            quot_x <= div_quot;
            state  <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            is_red       <= frame_red;
            frame_done   <= 1'b1;
            centroid_x   <= (tally == '0) ? '0 : CENT_W'(quot_x);
            centroid_y   <= (tally == '0) ? '0 : CENT_W'(div_quot);
            red_count    <= COUNT_W'(tally);
            sum_x        <= '0;
            sum_y        <= '0;
            tally        <= '0;
            state        <= S_PASS;
          end
        end
        default: begin
          state <= S_PASS;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/red_pixel_centroid_tracker.sv =====
// ----------------------------------------------------------------------------
// red_pixel_centroid_tracker
// Marks red pixels of a raster stream and reports the rounded centroid and
// count of red pixels at the end of each frame.
// ----------------------------------------------------------------------------
// Ordinary pixels pass at one per clock while the result is not stalled and
// the back is not busy with a frame end: the front classifies a pixel and
// counts its position in the cycle it is taken and writes it into the queue,
// and the back folds it into the sums when it pops it. The last pixel of a
// frame holds the back longer, because one restoring divider, one quotient
// bit per cycle, forms the x and then the y mean. A four-entry queue between
// front and back keeps taking pixels during that time until it is full, and
// the back pops no new pixel while the previous result is still stalled.
`default_nettype none

module red_pixel_centroid_tracker #(
  parameter int MAX_WIDTH  = rpct_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rpct_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  logic [rpct_pkg::PIX_W-1:0]      pixel_blue,
  input  logic [rpct_pkg::PIX_W-1:0]      pixel_green,
  input  logic [rpct_pkg::PIX_W-1:0]      pixel_red,
  input  logic                            last_in_frame,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            is_red,
  output logic                            frame_done,
  output logic [rpct_pkg::CENT_W-1:0]     centroid_x,
  output logic [rpct_pkg::CENT_W-1:0]     centroid_y,
  output logic [rpct_pkg::COUNT_W-1:0]    red_count
);
  import rpct_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int IW = CW + RW + 2;

  logic          accept;
  logic [IW-1:0] front_item;
  logic [IW-1:0] queue_item;
  logic          queue_full;
  logic          queue_empty;
  logic          queue_pop;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = queue_full;
  assign accept      = pixel_valid && !queue_full;

  rpct_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .pixel_blue    (pixel_blue),
    .pixel_green   (pixel_green),
    .pixel_red     (pixel_red),
    .last_in_frame (last_in_frame),
    .item          (front_item)
  );

  rpct_queue #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .wr_data (front_item),
    .pop     (queue_pop),
    .rd_data (queue_item),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  rpct_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!queue_empty),
    .q_data       (queue_item),
    .q_pop        (queue_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_red       (is_red),
    .frame_done   (frame_done),
    .centroid_x   (centroid_x),
    .centroid_y   (centroid_y),
    .red_count    (red_count)
  );

endmodule

`default_nettype wire
